[sv/ned_pkg.sv]
// ----------------------------------------------------------------------------
// ned_pkg
// Shared constants, types and codes for the normalized edit distance unit.
// ----------------------------------------------------------------------------
package ned_pkg;

	localparam int MAX_LEN   = 64;
	localparam int SYM_BITS  = 16;
	localparam int LEN_W     = $clog2(MAX_LEN + 1);
	localparam int ADDR_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int CNT_W     = $clog2(2 * MAX_LEN + 2);
	localparam int FRAC_BITS = 16;
	localparam int DIST_W    = 7;
	localparam int NORM_W    = 17;
	localparam int QUO_W     = DIST_W + FRAC_BITS;
	localparam int QCNT_W    = $clog2(QUO_W + 1);

	typedef enum logic [1:0] {
		ACT_LOAD_A  = 2'd0,
		ACT_LOAD_B  = 2'd1,
		ACT_COMPUTE = 2'd2,
		ACT_NONE    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_EMPTY    = 2'd1,
		STS_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_RUN,
		ST_CAP,
		ST_DIV,
		ST_OUT
	} state_t;

	// data handed from one cell to the next
	typedef struct packed {
		logic                vld;
		logic [SYM_BITS-1:0] sym;
		logic [LEN_W-1:0]    left;
		logic [LEN_W-1:0]    diag;
	} ned_link_t;

endpackage

[sv/normalized_edit_distance_top.sv]
// ----------------------------------------------------------------------------
// normalized_edit_distance_top
// Levenshtein distance of two loaded symbol sequences, plus the distance
// normalized to the longer length in unsigned Q1.16.
//
// Input channel (in_valid/in_stall, action, symbol): action 0 and 1 append a
// symbol to the first or second sequence, and loads are taken back to back
// while the unit is idle; action 2 computes and clears both sequences; action
// 3 is ignored. Symbols past MAX_LEN are dropped and the result reports overflow.
// A compute transfer stalls the input through the cell row wavefront, the
// bit-serial divider and the load of the output register. Two empty
// sequences skip the wavefront and the divider, go straight to the output
// state and answer with status empty.
// Output channel (out_valid/out_stall): one transfer per compute; loads
// proceed while a result waits, a further compute waits until the output
// register is free. Reset empties both sequences and drops any result.
// ----------------------------------------------------------------------------
module normalized_edit_distance_top import ned_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          action,
	input  logic [15:0]         symbol,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [DIST_W-1:0]   edit_distance,
	output logic [DIST_W-1:0]   longer_length,
	output logic [NORM_W-1:0]   normalized_distance,
	output logic [1:0]          status
);

	state_t              state_q, state_d;
	logic [LEN_W-1:0]    len_a_q, len_b_q;
	logic                ovf_q;
	logic [CNT_W-1:0]    k_q;
	logic [SYM_BITS-1:0] mem_a [MAX_LEN];
	logic [SYM_BITS-1:0] mem_rd_s1;
	logic                feed_s1;
	logic [LEN_W-1:0]    row_s1;
	logic [DIST_W-1:0]   dist_q;
	logic [DIST_W-1:0]   longer_q;
	logic [NORM_W-1:0]   norm_q;
	status_t             sts_q;
	logic                out_vld_q;
	logic [DIST_W-1:0]   o_dist_q, o_longer_q;
	logic [NORM_W-1:0]   o_norm_q;
	status_t             o_sts_q;

	logic                acc;
	action_t             act;
	logic [LEN_W-1:0]    longer_c;
	logic                a_full, b_full;
	logic                feed_c;
	logic                run_end;
	logic                init_c;
	logic                div_start;
	logic                div_busy, div_done;
	logic [NORM_W-1:0]   div_quo;
	logic [LEN_W-1:0]    cost_sel;
	logic [DIST_W-1:0]   dist_c;
	logic                out_free;
	ned_link_t           head;

	assign act      = action_t'(action);
	assign acc      = in_valid && !in_stall;
	assign longer_c = (len_a_q >= len_b_q) ? len_a_q : len_b_q;
	assign a_full   = (len_a_q == LEN_W'(MAX_LEN));
	assign b_full   = (len_b_q == LEN_W'(MAX_LEN));
	assign feed_c   = (k_q < CNT_W'(len_a_q));
	assign run_end  = (k_q == CNT_W'(len_a_q) + CNT_W'(len_b_q) + CNT_W'(1));
	assign out_free = !out_vld_q || !out_stall;
	assign dist_c   = (len_b_q == '0) ? DIST_W'(len_a_q) : DIST_W'(cost_sel);
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		init_c    = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && act == ACT_COMPUTE) begin
					state_d = (longer_c == '0) ? ST_OUT : ST_INIT;
				end
			end
			ST_INIT: begin
				init_c  = 1'b1;
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (run_end) begin
					state_d = ST_CAP;
				end
			end
			ST_CAP: begin
				div_start = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q   <= '0;
			len_b_q   <= '0;
			ovf_q     <= 1'b0;
			k_q       <= '0;
			feed_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			feed_s1 <= (state_q == ST_RUN) && feed_c;
			if (state_q == ST_INIT) begin
				k_q <= '0;
			end else if (state_q == ST_RUN) begin
				k_q <= k_q + CNT_W'(1);
			end
			if (acc && act == ACT_LOAD_A) begin
				if (a_full) ovf_q <= 1'b1;
				else len_a_q <= len_a_q + LEN_W'(1);
			end
			if (acc && act == ACT_LOAD_B) begin
				if (b_full) ovf_q <= 1'b1;
				else len_b_q <= len_b_q + LEN_W'(1);
			end
			if (state_q == ST_OUT && out_free) begin
				out_vld_q <= 1'b1;
				len_a_q   <= '0;
				len_b_q   <= '0;
				ovf_q     <= 1'b0;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && act == ACT_LOAD_A && !a_full) begin
			mem_a[len_a_q[ADDR_W-1:0]] <= symbol[SYM_BITS-1:0];
		end
		mem_rd_s1 <= mem_a[k_q[ADDR_W-1:0]];
		row_s1    <= LEN_W'(k_q) + LEN_W'(1);
		if (state_q == ST_IDLE && acc && act == ACT_COMPUTE) begin
			longer_q <= DIST_W'(longer_c);
			dist_q   <= '0;
			norm_q   <= '0;
			sts_q    <= STS_EMPTY;
		end
		if (state_q == ST_CAP) begin
			dist_q <= dist_c;
			sts_q  <= ovf_q ? STS_OVERFLOW : STS_OK;
		end
		if (state_q == ST_DIV && div_done) begin
			norm_q <= div_quo;
		end
		if (state_q == ST_OUT && out_free) begin
			o_dist_q   <= dist_q;
			o_longer_q <= longer_q;
			o_norm_q   <= norm_q;
			o_sts_q    <= sts_q;
		end
	end

	assign head = '{vld: feed_s1, sym: mem_rd_s1, left: row_s1,
		diag: row_s1 - LEN_W'(1)};

	ned_array u_array (
		.clk      (clk),
		.arst_n   (arst_n),
		.init     (init_c),
		.load     (acc && act == ACT_LOAD_B && !b_full),
		.load_idx (len_b_q[ADDR_W-1:0]),
		.load_sym (symbol[SYM_BITS-1:0]),
		.head     (head),
		.sel      (ADDR_W'(len_b_q - LEN_W'(1))),
		.cost_sel (cost_sel)
	);

	ned_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dist_c),
		.divisor  (longer_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_valid           = out_vld_q;
	assign edit_distance       = o_dist_q;
	assign longer_length       = o_longer_q;
	assign normalized_distance = o_norm_q;
	assign status              = o_sts_q;

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> state_q == ST_DIV)
		else $error("divider busy outside divide phase");

	a_empty_fast: assert property (@(posedge clk) disable iff (!arst_n)
		acc && act == ACT_COMPUTE && len_a_q == '0 && len_b_q == '0
		|=> state_q == ST_OUT)
		else $error("empty compute did not go straight to output");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> normalized_distance <= NORM_W'(1 << FRAC_BITS)
		&& edit_distance <= longer_length)
		else $error("result out of range");

endmodule

[sv/ned_cell.sv]
// ----------------------------------------------------------------------------
// ned_cell
// One column of the cost row: holds a second-sequence symbol and its cost.
// ----------------------------------------------------------------------------
module ned_cell import ned_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                init,
	input  logic [LEN_W-1:0]    init_val,
	input  logic                load_en,
	input  logic [SYM_BITS-1:0] load_sym,
	input  ned_link_t           link_in,
	output ned_link_t           link_out,
	output logic [LEN_W-1:0]    cost
);

	logic [SYM_BITS-1:0] b_q;
	logic [LEN_W-1:0]    cost_q;
	logic [LEN_W-1:0]    best;
	logic [LEN_W-1:0]    nxt;
	logic                vld_q;
	logic [SYM_BITS-1:0] sym_q;
	logic [LEN_W-1:0]    left_q;
	logic [LEN_W-1:0]    diag_q;

	always_comb begin
		best = (cost_q < link_in.left) ? cost_q : link_in.left;
		best = (link_in.diag < best) ? link_in.diag : best;
		nxt  = (link_in.sym == b_q) ? link_in.diag : best + LEN_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= link_in.vld && !init;
		end
	end

	always_ff @(posedge clk) begin
		if (load_en) begin
			b_q <= load_sym;
		end
		if (init) begin
			cost_q <= init_val;
		end else if (link_in.vld) begin
			cost_q <= nxt;
		end
		sym_q  <= link_in.sym;
		left_q <= nxt;
		diag_q <= cost_q;
	end

	assign link_out = '{vld: vld_q, sym: sym_q, left: left_q, diag: diag_q};
	assign cost     = cost_q;

endmodule

[sv/ned_array.sv]
// ----------------------------------------------------------------------------
// ned_array
// Row of cells; first-sequence symbols stream through as a wavefront.
// ----------------------------------------------------------------------------
module ned_array import ned_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                init,
	input  logic                load,
	input  logic [ADDR_W-1:0]   load_idx,
	input  logic [SYM_BITS-1:0] load_sym,
	input  ned_link_t           head,
	input  logic [ADDR_W-1:0]   sel,
	output logic [LEN_W-1:0]    cost_sel
);

	ned_link_t        links [MAX_LEN+1];
	logic [LEN_W-1:0] costs [MAX_LEN];

	assign links[0] = head;

	for (genvar g = 0; g < MAX_LEN; g++) begin : g_cell
		ned_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.init     (init),
			.init_val (LEN_W'(g + 1)),
			.load_en  (load && (load_idx == ADDR_W'(g))),
			.load_sym (load_sym),
			.link_in  (links[g]),
			.link_out (links[g+1]),
			.cost     (costs[g])
		);
	end

	assign cost_sel = costs[sel];

endmodule

[sv/ned_div.sv]
// ----------------------------------------------------------------------------
// ned_div
// Restoring divider, one quotient bit per cycle: (dist << 16) / longer.
// ----------------------------------------------------------------------------
module ned_div import ned_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIST_W-1:0] dividend,
	input  logic [DIST_W-1:0] divisor,
	output logic              busy,
	output logic              done,
	output logic [NORM_W-1:0] quotient
);

	logic [QCNT_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [QUO_W-1:0]  quo_q;
	logic [DIST_W-1:0] rem_q;
	logic [DIST_W-1:0] div_q;
	logic [DIST_W:0]   trial;
	logic [DIST_W:0]   diff;

	always_comb begin
		trial = {rem_q, quo_q[QUO_W-1]};
		diff  = trial - {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= QCNT_W'(QUO_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - QCNT_W'(1);
				if (cnt_q == QCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= {dividend, FRAC_BITS'(0)};
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, div_q}) begin
				rem_q <= diff[DIST_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[DIST_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q[NORM_W-1:0];

endmodule
